### src/qese_pkg.sv
// Shared constants and types for the quadrature encoder speed estimator.
package qese_pkg;

  localparam int unsigned COUNTER_RANGE_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned MUL_B_W  = 32;
  localparam int unsigned STEP_W   = 7;
  localparam int unsigned PPR_W    = 16;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned TWOPI_FB = 30;

  localparam logic [WORD_W-1:0] TWOPI_Q30  = 64'd6746518852;
  localparam logic [PPR_W-1:0]  PPR_MAX    = 16'd32768;
  localparam logic [PPR_W-1:0]  PPR_RESET  = 16'd2048;
  localparam logic [PPR_W-1:0]  RATE_RESET = 16'd1000;

  typedef enum logic {
    REG_PPR  = 1'b0,
    REG_RATE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } unit_req_t;

endpackage

### src/qese_div.sv
// Bit-serial restoring divider retiring one quotient bit per cycle.
module qese_div #(
  parameter int unsigned NUM_W = qese_pkg::WORD_W,
  parameter int unsigned DEN_W = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qese_pkg::unit_req_t req_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic                done_o,
  output logic [NUM_W-1:0]    quo_o,
  output logic [DEN_W-1:0]    rem_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [qese_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]            nq_q, nq_d;
  logic [DEN_W-1:0]            rem_q, rem_d;
  logic [DEN_W-1:0]            den_q, den_d;
  logic [DEN_W:0]              part;
  logic                        ge;

  assign part = {rem_q, nq_q[NUM_W-1]};
  assign ge   = part >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      nq_d  = {nq_q[NUM_W-2:0], ge};
      rem_d = ge ? DEN_W'(part - {1'b0, den_q}) : part[DEN_W-1:0];
      cnt_d = cnt_q - qese_pkg::STEP_W'(1);
      if (cnt_q == qese_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;
  assign rem_o  = rem_q;

endmodule

### src/qese_mul.sv
// Bit-serial shift-and-add multiplier consuming one multiplier bit per cycle.
module qese_mul #(
  parameter int unsigned A_W = qese_pkg::WORD_W,
  parameter int unsigned B_W = qese_pkg::MUL_B_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qese_pkg::unit_req_t req_i,
  input  logic [A_W-1:0]      a_i,
  input  logic [B_W-1:0]      b_i,
  output logic                done_o,
  output logic [A_W-1:0]      prod_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [qese_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [A_W-1:0]              acc_q, acc_d;
  logic [A_W-1:0]              a_q, a_d;
  logic [B_W-1:0]              b_q, b_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      acc_d = b_q[0] ? acc_q + a_q : acc_q;
      a_d   = {a_q[A_W-2:0], 1'b0};
      b_d   = {1'b0, b_q[B_W-1:1]};
      cnt_d = cnt_q - qese_pkg::STEP_W'(1);
      if (cnt_q == qese_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### src/quadrature_encoder_speed_estimator.sv
// Top level of the quadrature encoder speed estimator with its sequencer and register port.
// Each input transfer carries one encoder counter sample and a clear flag; the block unwraps
// the count change, keeps a saturating pulse total and returns one result transfer with
// position in pulses, revolutions, millimetres and radians, speed in pulses/s, rpm, rad/s and
// mm/s, and angular acceleration; pulse counts and pulses/s are signed integers and the rest
// is signed fixed point with FRAC_BITS fraction bits, rounded to nearest and saturated. Items
// are handled one at a time from acceptance to result: a sequencer runs eight bit-serial
// multiplications of 6 to 32 steps, and two short divisions and six 64-step divisions on the
// single shared restoring divider, which retires one quotient bit per cycle. A finished result
// waits in an output register, so the next sample is taken while it is still pending.
module quadrature_encoder_speed_estimator #(
  parameter int unsigned COUNTER_RANGE = qese_pkg::COUNTER_RANGE_DEF,
  parameter int unsigned FRAC_BITS     = qese_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [15:0] counter_sample, [16] clear_position, [23:17] zero
  input  logic [23:0]   s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [15:0] delta_counts, [47:16] pulse_position, [79:48] revolutions_q16,
  // [127:80] distance_mm_q16, [175:128] angle_rad_q16, [207:176] pulses_per_second,
  // [255:208] speed_rpm_q16, [303:256] speed_radps_q16, [351:304] speed_mmps_q16,
  // [415:352] accel_radps2_q16
  output logic [415:0]  m_axis_tdata_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned WORD_W   = qese_pkg::WORD_W;
  localparam int unsigned MUL_B_W  = qese_pkg::MUL_B_W;
  localparam int unsigned STEP_W   = qese_pkg::STEP_W;
  localparam int unsigned PPR_W    = qese_pkg::PPR_W;
  localparam int unsigned CNT_W    = qese_pkg::CNT_W;
  localparam int unsigned TWOPI_SH = qese_pkg::TWOPI_FB - FRAC_BITS;
  localparam int unsigned DEN_W    = PPR_W + TWOPI_SH;
  localparam logic [CNT_W-1:0] CR_V = CNT_W'(COUNTER_RANGE);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned D_W      = 18;
  localparam int unsigned DV_W     = 49;
  localparam int unsigned DELTA_W  = 16;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned Q48_W    = 48;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned K_W      = 6;

  localparam logic [K_W-1:0] K_ONE   = 6'd1;
  localparam logic [K_W-1:0] K_TEN   = 6'd10;
  localparam logic [K_W-1:0] K_SIXTY = 6'd60;

  localparam logic [STEP_W-1:0] STEPS_RATE  = STEP_W'(16);
  localparam logic [STEP_W-1:0] STEPS_MAG   = STEP_W'(MUL_B_W);
  localparam logic [STEP_W-1:0] STEPS_K     = STEP_W'(K_W);
  localparam logic [STEP_W-1:0] STEPS_WORD  = STEP_W'(WORD_W);
  localparam logic [STEP_W-1:0] STEPS_NOW   = STEP_W'(SAMPLE_W);
  localparam logic [STEP_W-1:0] STEPS_PER   = STEP_W'(CNT_W);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_NOW   = 10'b0000000010,
    ST_PER   = 10'b0000000100,
    ST_DELTA = 10'b0000001000,
    ST_TOTAL = 10'b0000010000,
    ST_PPS   = 10'b0000100000,
    ST_MUL   = 10'b0001000000,
    ST_DIV   = 10'b0010000000,
    ST_ACCEL = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  typedef enum logic [2:0] {
    JOB_RADPS = 3'd0,
    JOB_REV   = 3'd1,
    JOB_MM    = 3'd2,
    JOB_ANG   = 3'd3,
    JOB_RPM   = 3'd4,
    JOB_MMPS  = 3'd5
  } job_e;

  function automatic logic [63:0] sat_mag(input logic [63:0] mag, input logic neg,
                                          input int unsigned w);
    logic [63:0] lim;
    logic [63:0] res;
    lim = 64'd1 << (w - 1);
    if (neg) begin
      res = (mag > lim) ? (64'd0 - lim) : (64'd0 - mag);
    end else begin
      res = (mag > lim - 64'd1) ? (lim - 64'd1) : mag;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  state_e                state_q, state_d;
  job_e                  job_q, job_d;
  logic                  start_q, start_d;
  logic [PPR_W-1:0]      ppr_q, ppr_d;
  logic [PPR_W-1:0]      rate_q, rate_d;
  logic [SAMPLE_W-1:0]   prev_q, prev_d;
  logic [POS_W-1:0]      total_q, total_d;
  logic [Q48_W-1:0]      prev_radps_q, prev_radps_d;
  logic                  out_valid_q, out_valid_d;

  logic [SAMPLE_W-1:0]   sample_q, sample_d;
  logic                  clr_q, clr_d;
  logic [SAMPLE_W-1:0]   now_q, now_d;
  logic [CNT_W-1:0]      period_q, period_d;
  logic [D_W-1:0]        d_q, d_d;
  logic [POS_W-1:0]      pps_q, pps_d;
  logic [Q48_W-1:0]      radps_q, radps_d;
  logic [POS_W-1:0]      rev_q, rev_d;
  logic [Q48_W-1:0]      mm_q, mm_d;
  logic [Q48_W-1:0]      ang_q, ang_d;
  logic [Q48_W-1:0]      rpm_q, rpm_d;
  logic [Q48_W-1:0]      mmps_q, mmps_d;
  logic [ACC_W-1:0]      accel_q, accel_d;
  logic [415:0]          out_q, out_d;

  logic [PPR_W-1:0]      ppr_c;
  logic                  cfg_wr;
  logic signed [D_W-1:0] diff;
  logic signed [D_W-1:0] half_s;
  logic signed [D_W-1:0] per_s;
  logic [D_W-1:0]        unwrap;
  logic [CNT_W-1:0]      per_raw;
  logic [POS_W:0]        tot_sum;
  logic [POS_W-1:0]      tot_base;
  logic                  d_neg;
  logic [D_W-1:0]        d_mag;
  logic [POS_W-1:0]      total_mag;
  logic [POS_W-1:0]      pps_mag;
  logic [DV_W-1:0]       dv;
  logic [DV_W-1:0]       dv_mag;
  logic [63:0]           job_val;
  logic [DELTA_W-1:0]    delta_val;

  logic                  job_twopi;
  logic                  job_total;
  logic [K_W-1:0]        job_k;
  int unsigned           job_w;
  logic                  job_neg;
  logic [POS_W-1:0]      job_mag;
  logic [DEN_W-1:0]      job_den;

  qese_pkg::unit_req_t   div_req, mul_req;
  logic [WORD_W-1:0]     div_num;
  logic [DEN_W-1:0]      div_den;
  logic                  div_done;
  logic [WORD_W-1:0]     div_quo;
  logic [DEN_W-1:0]      div_rem;
  logic [WORD_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic                  mul_done;
  logic [WORD_W-1:0]     mul_prod;
  logic [STEP_W-1:0]     div_steps;
  logic [STEP_W-1:0]     mul_steps;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? {16'd0, rate_q} : {16'd0, ppr_q};

  always_comb begin
    if (ppr_q == '0) begin
      ppr_c = PPR_W'(1);
    end else if (ppr_q > qese_pkg::PPR_MAX) begin
      ppr_c = qese_pkg::PPR_MAX;
    end else begin
      ppr_c = ppr_q;
    end
  end

  assign diff    = $signed({2'b00, now_q}) - $signed({2'b00, prev_q});
  assign half_s  = $signed({2'b00, period_q[CNT_W-1:1]});
  assign per_s   = $signed({1'b0, period_q});
  assign per_raw = CR_V - CNT_W'(div_rem);

  always_comb begin
    if (diff > half_s) begin
      unwrap = diff - per_s;
    end else if (diff < -half_s) begin
      unwrap = diff + per_s;
    end else begin
      unwrap = diff;
    end
  end

  assign d_neg     = d_q[D_W-1];
  assign d_mag     = d_neg ? (D_W'(0) - d_q) : d_q;
  assign tot_base  = clr_q ? '0 : total_q;
  assign tot_sum   = {tot_base[POS_W-1], tot_base} + {{(POS_W + 1 - D_W){d_q[D_W-1]}}, d_q};
  assign total_mag = total_q[POS_W-1] ? (POS_W'(0) - total_q) : total_q;
  assign pps_mag   = pps_q[POS_W-1] ? (POS_W'(0) - pps_q) : pps_q;
  assign dv        = {radps_q[Q48_W-1], radps_q} - {prev_radps_q[Q48_W-1], prev_radps_q};
  assign dv_mag    = dv[DV_W-1] ? (DV_W'(0) - dv) : dv;
  assign delta_val = DELTA_W'(sat_mag(abs64({{(64 - D_W){d_q[D_W-1]}}, d_q}), d_neg, DELTA_W));

  always_comb begin
    job_twopi = 1'b0;
    job_total = 1'b0;
    job_k     = K_ONE;
    job_w     = Q48_W;
    unique case (job_q)
      JOB_RADPS: job_twopi = 1'b1;
      JOB_REV: begin
        job_total = 1'b1;
        job_w     = POS_W;
      end
      JOB_MM: begin
        job_total = 1'b1;
        job_k     = K_TEN;
      end
      JOB_ANG: begin
        job_twopi = 1'b1;
        job_total = 1'b1;
      end
      JOB_RPM:  job_k = K_SIXTY;
      JOB_MMPS: job_k = K_TEN;
      default:  job_twopi = 1'b1;
    endcase
  end

  assign job_neg = job_total ? total_q[POS_W-1] : pps_q[POS_W-1];
  assign job_mag = job_total ? total_mag : pps_mag;
  assign job_den = job_twopi ? (DEN_W'(ppr_c) << TWOPI_SH) : DEN_W'(ppr_c);
  assign job_val = sat_mag(div_quo, job_neg, job_w);

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_steps = STEPS_RATE;
    div_num   = mul_prod + WORD_W'(job_den >> 1);
    div_den   = job_den;
    div_steps = STEPS_WORD;
    unique case (state_q)
      ST_NOW: begin
        div_num   = {sample_q, {(WORD_W - SAMPLE_W){1'b0}}};
        div_den   = DEN_W'(CR_V);
        div_steps = STEPS_NOW;
      end
      ST_PER: begin
        div_num   = {CR_V, {(WORD_W - CNT_W){1'b0}}};
        div_den   = DEN_W'(ppr_c);
        div_steps = STEPS_PER;
      end
      ST_PPS: begin
        mul_a = WORD_W'(d_mag);
        mul_b = MUL_B_W'(rate_q);
      end
      ST_ACCEL: begin
        mul_a = WORD_W'(dv_mag);
        mul_b = MUL_B_W'(rate_q);
      end
      ST_MUL: begin
        if (job_twopi) begin
          mul_a     = qese_pkg::TWOPI_Q30;
          mul_b     = job_mag;
          mul_steps = STEPS_MAG;
        end else begin
          mul_a     = WORD_W'(job_mag) << FRAC_BITS;
          mul_b     = MUL_B_W'(job_k);
          mul_steps = STEPS_K;
        end
      end
      default: ;
    endcase
  end

  assign div_req.start = start_q & ((state_q == ST_NOW) | (state_q == ST_PER) |
                                    (state_q == ST_DIV));
  assign div_req.steps = div_steps;
  assign mul_req.start = start_q & ((state_q == ST_PPS) | (state_q == ST_MUL) |
                                    (state_q == ST_ACCEL));
  assign mul_req.steps = mul_steps;

  qese_div #(
    .NUM_W (WORD_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  qese_mul #(
    .A_W (WORD_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    start_d      = 1'b0;
    ppr_d        = ppr_q;
    rate_d       = rate_q;
    prev_d       = prev_q;
    total_d      = total_q;
    prev_radps_d = prev_radps_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    sample_d     = sample_q;
    clr_d        = clr_q;
    now_d        = now_q;
    period_d     = period_q;
    d_d          = d_q;
    pps_d        = pps_q;
    radps_d      = radps_q;
    rev_d        = rev_q;
    mm_d         = mm_q;
    ang_d        = ang_q;
    rpm_d        = rpm_q;
    mmps_d       = mmps_q;
    accel_d      = accel_q;
    out_d        = out_q;

    if (cfg_wr) begin
      unique case (qese_pkg::reg_idx_e'(paddr[2]))
        qese_pkg::REG_PPR:  ppr_d  = pwdata[PPR_W-1:0];
        qese_pkg::REG_RATE: rate_d = pwdata[PPR_W-1:0];
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          sample_d = s_axis_tdata_i[SAMPLE_W-1:0];
          clr_d    = s_axis_tdata_i[SAMPLE_W];
          state_d  = ST_NOW;
          start_d  = 1'b1;
        end
      end
      ST_NOW: begin
        if (div_done) begin
          now_d   = div_rem[SAMPLE_W-1:0];
          state_d = ST_PER;
          start_d = 1'b1;
        end
      end
      ST_PER: begin
        if (div_done) begin
          period_d = (per_raw == '0) ? CR_V : per_raw;
          state_d  = ST_DELTA;
        end
      end
      ST_DELTA: begin
        d_d     = unwrap;
        prev_d  = now_q;
        state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        total_d = POS_W'(sat_mag(abs64({{(64 - POS_W - 1){tot_sum[POS_W]}}, tot_sum}),
                                 tot_sum[POS_W], POS_W));
        state_d = ST_PPS;
        start_d = 1'b1;
      end
      ST_PPS: begin
        if (mul_done) begin
          pps_d   = POS_W'(sat_mag(mul_prod, d_neg, POS_W));
          job_d   = JOB_RADPS;
          state_d = ST_MUL;
          start_d = 1'b1;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_DIV;
          start_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          start_d = 1'b1;
          state_d = ST_MUL;
          unique case (job_q)
            JOB_RADPS: begin
              radps_d = job_val[Q48_W-1:0];
              state_d = ST_ACCEL;
            end
            JOB_REV: begin
              rev_d = job_val[POS_W-1:0];
              job_d = JOB_MM;
            end
            JOB_MM: begin
              mm_d  = job_val[Q48_W-1:0];
              job_d = JOB_ANG;
            end
            JOB_ANG: begin
              ang_d = job_val[Q48_W-1:0];
              job_d = JOB_RPM;
            end
            JOB_RPM: begin
              rpm_d = job_val[Q48_W-1:0];
              job_d = JOB_MMPS;
            end
            default: begin
              mmps_d  = job_val[Q48_W-1:0];
              state_d = ST_OUT;
              start_d = 1'b0;
            end
          endcase
        end
      end
      ST_ACCEL: begin
        if (mul_done) begin
          accel_d      = sat_mag(mul_prod, dv[DV_W-1], ACC_W);
          prev_radps_d = radps_q;
          job_d        = JOB_REV;
          state_d      = ST_MUL;
          start_d      = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = {accel_q, mmps_q, radps_q, rpm_q, pps_q,
                         ang_q, mm_q, rev_q, total_q, delta_val};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      job_q        <= JOB_RADPS;
      start_q      <= 1'b0;
      ppr_q        <= qese_pkg::PPR_RESET;
      rate_q       <= qese_pkg::RATE_RESET;
      prev_q       <= '0;
      total_q      <= '0;
      prev_radps_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      job_q        <= job_d;
      start_q      <= start_d;
      ppr_q        <= ppr_d;
      rate_q       <= rate_d;
      prev_q       <= prev_d;
      total_q      <= total_d;
      prev_radps_q <= prev_radps_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    clr_q    <= clr_d;
    now_q    <= now_d;
    period_q <= period_d;
    d_q      <= d_d;
    pps_q    <= pps_d;
    radps_q  <= radps_d;
    rev_q    <= rev_d;
    mm_q     <= mm_d;
    ang_q    <= ang_d;
    rpm_q    <= rpm_d;
    mmps_q   <= mmps_d;
    accel_q  <= accel_d;
    out_q    <= out_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

### tb/qese_motion_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each encoder motion result from the sample stream and compares it with the block.
module qese_motion_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [23:0]  s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [415:0] m_tdata_i,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  input  logic         pready_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int FRAC = 16;
  localparam int SPAN = 65536;
  localparam int N_FIELDS = 10;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam logic [2:0] PPR_ADDR  = 3'(qese_pkg::REG_PPR) << 2;
  localparam logic [2:0] RATE_ADDR = 3'(qese_pkg::REG_RATE) << 2;

  typedef struct packed {
    logic [63:0] accel;
    logic [47:0] mmps;
    logic [47:0] radps;
    logic [47:0] rpm;
    logic [31:0] pps;
    logic [47:0] angle;
    logic [47:0] distance;
    logic [31:0] revs;
    logic [31:0] pulses;
    logic [15:0] delta;
  } motion_t;

  logic [15:0]  cfg_ppr;
  logic [15:0]  cfg_rate;
  logic [15:0]  last_sample;
  longint       pulse_total;
  longint       last_radps;
  logic [415:0] motion_q[$];
  int           errors = 0;
  int           queued = 0;

  assign fail_count_o = errors;
  assign pending_o    = queued;

  function automatic int field_width(input int i);
    case (i)
      0:       return 16;
      1, 2, 5: return 32;
      9:       return 64;
      default: return 48;
    endcase
  endfunction

  function automatic string field_name(input int i);
    case (i)
      0:       return "delta_counts";
      1:       return "pulse_position";
      2:       return "revolutions_q16";
      3:       return "distance_mm_q16";
      4:       return "angle_rad_q16";
      5:       return "pulses_per_second";
      6:       return "speed_rpm_q16";
      7:       return "speed_radps_q16";
      8:       return "speed_mmps_q16";
      default: return "accel_radps2_q16";
    endcase
  endfunction

  function automatic longint saturate(input longint v, input int w);
    longint hi;
    if (w >= 64) return v;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? -$unsigned(v) : $unsigned(v);
  endfunction

  function automatic longint round_div(input longint unsigned mag, input longint unsigned den,
                                       input bit neg);
    longint unsigned q;
    q = (mag + den / 2) / den;
    if (q > 64'h7FFF_FFFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scale_ppr(input longint v, input longint unsigned k,
                                       input int unsigned ppr);
    return round_div((magnitude(v) * k) << FRAC, 64'(ppr), v < 0);
  endfunction

  function automatic longint scale_twopi(input longint v, input int unsigned ppr);
    return round_div(magnitude(v) * TWO_PI_Q30, 64'(ppr) << (30 - FRAC), v < 0);
  endfunction

  function automatic motion_t motion_from_sample(input logic [15:0] smp, input logic clr);
    int unsigned     ppr;
    longint          period;
    longint          d;
    longint          pps;
    longint          radps;
    longint          dv;
    longint          accel;
    longint unsigned m;
    logic [127:0]    prod;
    motion_t         r;
    ppr = cfg_ppr == 16'd0 ? 1 : (cfg_ppr > 16'd32768 ? 32768 : int'(cfg_ppr));
    period = SPAN - (SPAN % ppr);
    if (period == 0) period = SPAN;
    if (clr) pulse_total = 0;
    d = longint'(smp % SPAN) - longint'(last_sample);
    if (d > period / 2) d -= period;
    else if (d < -(period / 2)) d += period;
    last_sample = smp;
    pulse_total = saturate(pulse_total + d, 32);
    pps = saturate(d * longint'(cfg_rate), 32);
    radps = saturate(scale_twopi(pps, ppr), 48);
    accel = 0;
    if (cfg_rate != 16'd0) begin
      dv = radps - last_radps;
      m = magnitude(dv);
      prod = 128'(m) * 128'(cfg_rate);
      if (prod > 128'h7FFF_FFFF_FFFF_FFFF)
        accel = dv < 0 ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      else
        accel = dv < 0 ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    end
    last_radps = radps;
    r.delta    = 16'(saturate(d, 16));
    r.pulses   = 32'(pulse_total);
    r.revs     = 32'(saturate(scale_ppr(pulse_total, 1, ppr), 32));
    r.distance = 48'(saturate(scale_ppr(pulse_total, 10, ppr), 48));
    r.angle    = 48'(saturate(scale_twopi(pulse_total, ppr), 48));
    r.pps      = 32'(pps);
    r.rpm      = 48'(saturate(scale_ppr(pps, 60, ppr), 48));
    r.radps    = 48'(radps);
    r.mmps     = 48'(saturate(scale_ppr(pps, 10, ppr), 48));
    r.accel    = 64'(accel);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [415:0] want;
    logic [415:0] got;
    logic [63:0]  want_f;
    logic [63:0]  got_f;
    int           lo;
    int           wd;
    if (!rst_ni) begin
      cfg_ppr = qese_pkg::PPR_RESET;
      cfg_rate = qese_pkg::RATE_RESET;
      last_sample = '0;
      pulse_total = 0;
      last_radps = 0;
      motion_q.delete();
      queued = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == PPR_ADDR) cfg_ppr = pwdata_i[15:0];
        else if (paddr_i == RATE_ADDR) cfg_rate = pwdata_i[15:0];
      end
      if (m_tvalid_i && m_tready_i) begin
        if (motion_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, expected none, actual %h",
                   $time, m_tdata_i);
        end else begin
          want = motion_q.pop_front();
          got = m_tdata_i;
          lo = 0;
          for (int i = 0; i < N_FIELDS; i++) begin
            wd = field_width(i);
            want_f = 64'(want >> lo);
            got_f = 64'(got >> lo);
            if (wd < 64) begin
              want_f &= (64'd1 << wd) - 1;
              got_f &= (64'd1 << wd) - 1;
            end
            if (want_f != got_f) begin
              errors++;
              $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name(i),
                       want_f, got_f);
            end
            lo += wd;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        motion_q.push_back(motion_from_sample(s_tdata_i[15:0], s_tdata_i[16]));
      queued = motion_q.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, register writes, sample stream, result back-pressure and verdict.
module tb_top;

  localparam int STALL_LIMIT  = 8000;
  localparam int DRAIN_CYCLES = 600;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 136;
  localparam int N_DIRECTED   = 24;
  localparam logic [2:0] PPR_ADDR  = 3'(qese_pkg::REG_PPR) << 2;
  localparam logic [2:0] RATE_ADDR = 3'(qese_pkg::REG_RATE) << 2;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [23:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [415:0] m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  int           stall_left = 0;
  bit           idling = 0;
  logic [15:0]  last_sample = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quadrature_encoder_speed_estimator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  qese_motion_checker u_motion_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready = 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("quadrature_encoder_speed_estimator verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [15:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = {16'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    wait (pending == 0);
  endtask

  task automatic set_rates(input logic [15:0] ppr, input logic [15:0] rate);
    drain();
    reg_write(PPR_ADDR, ppr);
    reg_write(RATE_ADDR, rate);
  endtask

  task automatic push_sample(input logic [15:0] smp, input logic clr);
    @(negedge clk_i);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata = {7'd0, clr, smp};
    last_sample = smp;
    do @(posedge clk_i); while (!s_tready);
  endtask

  initial begin
    int          step;
    int          bias;
    int          dlt;
    logic [15:0] smp;
    logic [16:0] directed [N_DIRECTED];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    directed = '{17'h00000, 17'h0FFFF, 17'h00001, 17'h08001, 17'h00001, 17'h11234,
                 17'h11000, 17'h09000, 17'h01000, 17'h09000, 17'h01000, 17'h1FFFF,
                 17'h00000, 17'h04000, 17'h0C000, 17'h17FFF, 17'h00000, 17'h0FFFF,
                 17'h07FFF, 17'h0FFFE, 17'h07FFE, 17'h00000, 17'h05555, 17'h1AAAA};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      case (i)
        8:       set_rates(16'd0, 16'd65535);
        13:      set_rates(16'd65535, 16'd0);
        16:      set_rates(16'd3, 16'd1);
        21:      set_rates(16'd32768, 16'd65535);
        default: ;
      endcase
      push_sample(directed[i][15:0], directed[i][16]);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_rates(16'd1, 16'd65535);
        1:       set_rates(16'd32768, 16'd1);
        2:       set_rates(16'($urandom_range(1, 32768)), 16'($urandom_range(1, 65535)));
        3:       set_rates(16'd65535, 16'd0);
        4:       set_rates(16'($urandom_range(2, 999)), 16'($urandom_range(1, 65535)));
        5:       set_rates(16'd0, 16'($urandom_range(0, 65535)));
        default: set_rates(16'($urandom), 16'($urandom));
      endcase
      idling = (p != 2) && (p != PHASES - 1);
      step = 1 << $urandom_range(0, 13);
      bias = int'($urandom_range(0, step)) - step / 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) drain();
        case ($urandom_range(0, 9))
          0: smp = 16'($urandom);
          1: smp = last_sample + 16'h8000;
          default: begin
            dlt = int'($urandom_range(0, 2 * step)) - step + bias;
            smp = last_sample + 16'(dlt);
          end
        endcase
        push_sample(smp, $urandom_range(0, 19) == 0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("quadrature_encoder_speed_estimator verification clean");
    end else begin
      $display("quadrature_encoder_speed_estimator verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/qese_pkg.sv
src/qese_div.sv
src/qese_mul.sv
src/quadrature_encoder_speed_estimator.sv
tb/qese_motion_checker.sv
tb/tb_top.sv
